### rtl/core/first_fit_zone_allocator_top_assert.svh
// assertion macros of the allocator rtl, used by ffza_ctrl
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef FIRST_FIT_ZONE_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_ZONE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FFZA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffza assertion failed");

// next-cycle implication
`define FFZA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffza assertion failed");

`endif

### rtl/core/ffza_pkg.sv
// shared constants, types and helpers of the first-fit zone allocator
// no dependencies
package ffza_pkg;

    localparam int ARENA_BYTES        = 65536;
    localparam int HEADER_BYTES       = 24;
    localparam int MIN_FRAGMENT_BYTES = 64;
    localparam int TRAILER_BYTES      = 4;

    localparam int GRANULES  = ARENA_BYTES / 8;
    localparam int CAP       = GRANULES;
    localparam int IDX_W     = $clog2(GRANULES + 1);
    localparam int MAP_AW    = $clog2(GRANULES);
    localparam int GUARD_LIM = GRANULES + 2;
    localparam int GUARD_W   = $clog2(GRANULES + 4);
    localparam int FRAG_GRAN = MIN_FRAGMENT_BYTES / 8;
    localparam int PAD_BYTES = HEADER_BYTES + TRAILER_BYTES + 7;

    localparam int CMD_W  = 1;
    localparam int REQ_W  = 16;
    localparam int TAG_W  = 16;
    localparam int OFF_W  = 16;
    localparam int STAT_W = 3;
    localparam int RGN_W  = 17;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_ZERO_TAG     = 3'd2,
        ST_NOT_BLOCK    = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAP,
        OP_CLEAR,
        OP_LOAD,
        OP_A_PRV,
        OP_A_STOP,
        OP_A_RD,
        OP_A_EV,
        OP_A_W1,
        OP_A_W2,
        OP_F_RD,
        OP_F_CHK,
        OP_F_CLR,
        OP_F_M1,
        OP_F_RD2,
        OP_F_M2
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   ld_out;
        logic   ok_alloc;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic zero_tag;
        logic bad_off;
        logic a_found;
        logic a_fail;
        logic f_bad;
        logic f_dbl;
    } t_dp_flags;

    // block after b: the cap wraps to block 0, the region end leads to the cap
    function automatic logic [IDX_W-1:0] follow(input logic [IDX_W-1:0] b,
                                                 input logic [IDX_W-1:0] g,
                                                 input logic [IDX_W-1:0] rg);
        logic [IDX_W:0]   n;
        logic [IDX_W-1:0] res;
        n = {1'b0, b} + {1'b0, g};
        if (b >= IDX_W'(CAP)) begin
            res = '0;
        end else if (n >= {1'b0, rg}) begin
            res = IDX_W'(CAP);
        end else begin
            res = n[IDX_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/ffza_if.sv
// handshake channels of the allocator: request, response, configuration
// depends on ffza_pkg
interface ffza_req_if import ffza_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] request_bytes;
    logic [TAG_W-1:0] owner_tag;
    logic [OFF_W-1:0] release_offset;
    modport source (output valid, command, request_bytes, owner_tag, release_offset,
                    input ready);
    modport sink (input valid, command, request_bytes, owner_tag, release_offset,
                  output ready);
endinterface

interface ffza_rsp_if import ffza_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  payload_offset;
    logic [STAT_W-1:0] status;
    modport source (output valid, payload_offset, status, input ready);
    modport sink (input valid, payload_offset, status, output ready);
endinterface

interface ffza_cfg_if import ffza_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RGN_W-1:0] region_bytes;
    modport source (output valid, region_bytes, input ready);
    modport sink (input valid, region_bytes, output ready);
endinterface

### rtl/core/first_fit_zone_allocator_top.sv
// top level of the first-fit zone allocator
// depends on ffza_pkg, ffza_if, ffza_ctrl, ffza_dp
// One item at a time. After reset and after every region_bytes write the block runs a
// pass that rebuilds the arena (one start-map entry per cycle) and takes no item
// meanwhile. An allocate walks the block headers from the rover, and every step of
// the walk is one read of the header rams. The result sits in an output register,
// so the next item is taken while it waits.
module first_fit_zone_allocator_top import ffza_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    ffza_req_if.sink    i_req,
    ffza_rsp_if.source  o_rsp,
    ffza_cfg_if.sink    i_cfg
);
    t_dp_cmd   cmd;
    t_dp_flags flags;
    logic      cfg_fire;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;

    ffza_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .o_in_ready   (i_req.ready),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_out_status (o_rsp.status),
        .i_cfg_fire   (cfg_fire),
        .o_cmd        (cmd),
        .i_flags      (flags)
    );

    ffza_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_flags          (flags),
        .i_command        (i_req.command),
        .i_request_bytes  (i_req.request_bytes),
        .i_owner_tag      (i_req.owner_tag),
        .i_release_offset (i_req.release_offset),
        .i_cfg_we         (cfg_fire),
        .i_region_bytes   (i_cfg.region_bytes),
        .o_payload_offset (o_rsp.payload_offset)
    );
endmodule

### rtl/core/ffza_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffza_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/ffza_ctrl.sv
// sequencer of the allocator: init sweep, allocate scan and free merge steps
// depends on ffza_pkg and the assertion macro header
`include "first_fit_zone_allocator_top_assert.svh"

module ffza_ctrl import ffza_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_out_status,
    input  logic              i_cfg_fire,
    output t_dp_cmd           o_cmd,
    input  t_dp_flags         i_flags
);
    typedef enum logic [4:0] {
        S_CAP, S_CLR, S_IDLE, S_DISP,
        S_A_PRV, S_A_STOP, S_A_RD, S_A_EV, S_A_W1, S_A_W2,
        S_F_RD, S_F_CHK, S_F_CLR, S_F_M1, S_F_RD2, S_F_M2,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status, n_out_status;
    logic    in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        o_cmd        = '{op: OP_NOP, ld_out: 1'b0, ok_alloc: 1'b0};
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CAP: begin
                o_cmd.op = OP_CAP;
                n_state  = S_CLR;
            end
            S_CLR: begin
                o_cmd.op = OP_CLEAR;
                if (i_flags.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_flags.is_free) begin
                    if (i_flags.zero_tag) begin
                        n_status = ST_ZERO_TAG;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_A_PRV;
                    end
                end else if (i_flags.bad_off) begin
                    n_status = ST_NOT_BLOCK;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_A_PRV: begin
                o_cmd.op = OP_A_PRV;
                n_state  = S_A_STOP;
            end
            S_A_STOP: begin
                o_cmd.op = OP_A_STOP;
                n_state  = S_A_RD;
            end
            S_A_RD: begin
                o_cmd.op = OP_A_RD;
                n_state  = S_A_EV;
            end
            S_A_EV: begin
                o_cmd.op = OP_A_EV;
                if (i_flags.a_found) begin
                    n_state = S_A_W1;
                end else if (i_flags.a_fail) begin
                    n_status = ST_NO_SPACE;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_W1: begin
                o_cmd.op = OP_A_W1;
                n_state  = S_A_W2;
            end
            S_A_W2: begin
                o_cmd.op = OP_A_W2;
                n_status = ST_OK;
                n_state  = S_RESULT;
            end
            S_F_RD: begin
                o_cmd.op = OP_F_RD;
                n_state  = S_F_CHK;
            end
            S_F_CHK: begin
                o_cmd.op = OP_F_CHK;
                if (i_flags.f_bad) begin
                    n_status = ST_NOT_BLOCK;
                    n_state  = S_RESULT;
                end else if (i_flags.f_dbl) begin
                    n_status = ST_ALREADY_FREE;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_F_CLR;
                end
            end
            S_F_CLR: begin
                o_cmd.op = OP_F_CLR;
                n_state  = S_F_M1;
            end
            S_F_M1: begin
                o_cmd.op = OP_F_M1;
                n_state  = S_F_RD2;
            end
            S_F_RD2: begin
                o_cmd.op = OP_F_RD2;
                n_state  = S_F_M2;
            end
            S_F_M2: begin
                o_cmd.op = OP_F_M2;
                n_status = ST_OK;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out   = 1'b1;
                    o_cmd.ok_alloc = (r_status == ST_OK) && !i_flags.is_free;
                    n_out_valid    = 1'b1;
                    n_out_status   = r_status;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CAP;
            end
        endcase
        // a register write rebuilds the arena
        if (i_cfg_fire) begin
            n_state = S_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CAP;
            r_status     <= ST_OK;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_status     <= n_status;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;

    `FFZA_ASSERT_NXT(a_accept_dispatch, in_fire && !i_cfg_fire, r_state == S_DISP)
    `FFZA_ASSERT_NXT(a_cfg_rebuild, i_cfg_fire, r_state == S_CAP)
    `FFZA_ASSERT_NXT(a_scan_fail_status,
        r_state == S_A_EV && !i_flags.a_found && i_flags.a_fail && !i_cfg_fire,
        r_state == S_RESULT && r_status == ST_NO_SPACE)
    `FFZA_ASSERT_NXT(a_result_waits,
        r_state == S_RESULT && r_out_valid && !i_out_ready && !i_cfg_fire,
        r_state == S_RESULT && r_out_valid)
endmodule

### rtl/core/ffza_dp.sv
// datapath of the allocator: block header rams, scan registers, merge logic
// depends on ffza_pkg and ffza_ram
module ffza_dp import ffza_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_flags        o_flags,
    input  logic [CMD_W-1:0] i_command,
    input  logic [REQ_W-1:0] i_request_bytes,
    input  logic [TAG_W-1:0] i_owner_tag,
    input  logic [OFF_W-1:0] i_release_offset,
    input  logic             i_cfg_we,
    input  logic [RGN_W-1:0] i_region_bytes,
    output logic [OFF_W-1:0] o_payload_offset
);
    logic [IDX_W-1:0]   r_rg;
    logic [MAP_AW-1:0]  r_clr;
    logic [IDX_W-1:0]   r_rover;
    logic               r_is_free;
    logic [IDX_W-1:0]   r_need;
    logic [TAG_W-1:0]   r_tag;
    logic [OFF_W-1:0]   r_off;
    logic [IDX_W-1:0]   r_base, r_scan, r_stop;
    logic               r_pend;
    logic [GUARD_W-1:0] r_guard;
    logic [TAG_W-1:0]   r_bown;
    logic [IDX_W-1:0]   r_bgran;
    logic [IDX_W-1:0]   r_g, r_ggran, r_other;
    logic [OFF_W-1:0]   r_out_off;

    logic [IDX_W-1:0]  rd_idx;
    logic              own_we, gran_we, prev_we, map_we;
    logic [IDX_W-1:0]  own_wa, gran_wa, prev_wa;
    logic [MAP_AW-1:0] map_wa;
    logic [TAG_W-1:0]  own_wd, own_q;
    logic [IDX_W-1:0]  gran_wd, prev_wd, gran_q, prev_q;
    logic              map_wd, map_q;

    logic [RGN_W-1:0]  cfg_bytes;
    logic [IDX_W-1:0]  cfg_rg;
    logic [RGN_W-1:0]  need_sum;
    logic [OFF_W-1:0]  f_sub;
    logic [MAP_AW-1:0] f_g;
    logic              bad_off;
    logic [IDX_W-1:0]  f_next, m2_after, nxt;
    logic              same_b, b_fit, chk_fail, ev_found, ev_fail;
    logic [TAG_W-1:0]  b_own;
    logic [IDX_W-1:0]  b_gran;
    logic [IDX_W-1:0]  frag, extra, a_after, rov_alloc;
    logic              split;
    logic [IDX_W-1:0]  m_sum;
    logic [OFF_W+1:0]  base_bytes;

    ffza_ram #(.WIDTH(TAG_W), .DEPTH(GRANULES + 1)) u_owner (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_wa), .i_wdata(own_wd),
        .i_raddr(rd_idx), .o_rdata(own_q)
    );
    ffza_ram #(.WIDTH(IDX_W), .DEPTH(GRANULES + 1)) u_gran (
        .i_clk(i_clk), .i_we(gran_we), .i_waddr(gran_wa), .i_wdata(gran_wd),
        .i_raddr(rd_idx), .o_rdata(gran_q)
    );
    ffza_ram #(.WIDTH(IDX_W), .DEPTH(GRANULES + 1)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(rd_idx), .o_rdata(prev_q)
    );
    ffza_ram #(.WIDTH(1), .DEPTH(GRANULES)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_wa), .i_wdata(map_wd),
        .i_raddr(f_g), .o_rdata(map_q)
    );

    // region size clamped to the arena, whole granules, at least one
    always_comb begin
        cfg_bytes = (i_region_bytes > RGN_W'(ARENA_BYTES)) ? RGN_W'(ARENA_BYTES)
                                                           : i_region_bytes;
        cfg_rg = IDX_W'(cfg_bytes >> 3);
        if (cfg_rg == '0) begin
            cfg_rg = IDX_W'(1);
        end
    end

    assign need_sum = RGN_W'(i_request_bytes) + RGN_W'(PAD_BYTES);

    assign f_sub   = r_off - OFF_W'(HEADER_BYTES);
    assign f_g     = MAP_AW'(f_sub >> 3);
    assign bad_off = (r_off < OFF_W'(HEADER_BYTES)) || (f_sub[2:0] != 3'd0) ||
                     ((RGN_W'(f_sub) >> 3) >= RGN_W'(r_rg));

    assign f_next   = follow(r_g, r_ggran, r_rg);
    assign m2_after = follow(r_other, gran_q, r_rg);
    assign m_sum    = gran_q + r_ggran;

    // scan step: base data comes from the ram when base and scan coincide
    assign nxt      = follow(r_scan, gran_q, r_rg);
    assign same_b   = (r_base == r_scan);
    assign b_own    = same_b ? own_q : r_bown;
    assign b_gran   = same_b ? gran_q : r_bgran;
    assign b_fit    = (b_own == '0) && (b_gran >= r_need);
    assign chk_fail = (r_scan == r_stop) || (r_guard > GUARD_W'(GUARD_LIM));
    assign ev_found = (r_pend && b_fit) || (!chk_fail && (own_q == '0) && b_fit);
    assign ev_fail  = !(r_pend && b_fit) && chk_fail;

    assign frag      = r_base + r_need;
    assign extra     = r_bgran - r_need;
    assign split     = (extra > IDX_W'(FRAG_GRAN));
    assign a_after   = follow(r_base, r_bgran, r_rg);
    assign rov_alloc = follow(r_base, split ? r_need : r_bgran, r_rg);

    assign base_bytes = {r_base, 3'b000} + (OFF_W+2)'(HEADER_BYTES);

    always_comb begin
        rd_idx  = r_scan;
        own_we  = 1'b0;
        own_wa  = r_base;
        own_wd  = '0;
        gran_we = 1'b0;
        gran_wa = r_base;
        gran_wd = '0;
        prev_we = 1'b0;
        prev_wa = r_base;
        prev_wd = '0;
        map_we  = 1'b0;
        map_wa  = r_clr;
        map_wd  = 1'b0;
        case (i_cmd.op)
            OP_CAP: begin
                own_we  = 1'b1;
                own_wa  = IDX_W'(CAP);
                own_wd  = TAG_W'(1);
                gran_we = 1'b1;
                gran_wa = IDX_W'(CAP);
                prev_we = 1'b1;
                prev_wa = IDX_W'(CAP);
            end
            OP_CLEAR: begin
                map_we = 1'b1;
                map_wa = r_clr;
                map_wd = (r_clr == '0);
                if (r_clr == '0) begin
                    gran_we = 1'b1;
                    gran_wa = '0;
                    gran_wd = r_rg;
                    own_we  = 1'b1;
                    own_wa  = '0;
                    prev_we = 1'b1;
                    prev_wa = '0;
                    prev_wd = IDX_W'(CAP);
                end
            end
            OP_A_PRV: begin
                rd_idx = r_rover;
            end
            OP_A_RD: begin
                rd_idx = r_scan;
            end
            OP_A_W1: begin
                if (split) begin
                    map_we  = 1'b1;
                    map_wa  = frag[MAP_AW-1:0];
                    map_wd  = 1'b1;
                    gran_we = 1'b1;
                    gran_wa = frag;
                    gran_wd = extra;
                    own_we  = 1'b1;
                    own_wa  = frag;
                    prev_we = 1'b1;
                    prev_wa = frag;
                    prev_wd = r_base;
                end
            end
            OP_A_W2: begin
                own_we = 1'b1;
                own_wa = r_base;
                own_wd = r_tag;
                if (split) begin
                    prev_we = 1'b1;
                    prev_wa = a_after;
                    prev_wd = frag;
                    gran_we = 1'b1;
                    gran_wa = r_base;
                    gran_wd = r_need;
                end
            end
            OP_F_RD: begin
                rd_idx = IDX_W'(f_g);
            end
            OP_F_CLR: begin
                own_we = 1'b1;
                own_wa = r_g;
                rd_idx = r_other;
            end
            OP_F_M1: begin
                // merge into the free block before
                if (own_q == '0) begin
                    gran_we = 1'b1;
                    gran_wa = r_other;
                    gran_wd = m_sum;
                    prev_we = 1'b1;
                    prev_wa = f_next;
                    prev_wd = r_other;
                    map_we  = 1'b1;
                    map_wa  = r_g[MAP_AW-1:0];
                end
            end
            OP_F_RD2: begin
                rd_idx = f_next;
            end
            OP_F_M2: begin
                // absorb the free block after
                if (own_q == '0) begin
                    gran_we = 1'b1;
                    gran_wa = r_g;
                    gran_wd = m_sum;
                    prev_we = 1'b1;
                    prev_wa = m2_after;
                    prev_wd = r_g;
                    map_we  = 1'b1;
                    map_wa  = r_other[MAP_AW-1:0];
                end
            end
            default: begin
                rd_idx = r_scan;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rg <= IDX_W'(GRANULES);
        end else if (i_cfg_we) begin
            r_rg <= cfg_rg;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP: begin
                r_rover <= '0;
                r_clr   <= '0;
            end
            OP_CLEAR: begin
                r_clr <= r_clr + MAP_AW'(1);
            end
            OP_LOAD: begin
                r_is_free <= (i_command == CMD_FREE);
                r_need    <= IDX_W'(need_sum >> 3);
                r_tag     <= i_owner_tag;
                r_off     <= i_release_offset;
                r_base    <= r_rover;
                r_scan    <= r_rover;
                r_pend    <= 1'b0;
                r_guard   <= '0;
            end
            OP_A_STOP: begin
                r_stop <= prev_q;
            end
            OP_A_EV: begin
                if (same_b) begin
                    r_bown  <= own_q;
                    r_bgran <= gran_q;
                end
                if (!ev_found && !ev_fail) begin
                    r_guard <= r_guard + GUARD_W'(1);
                    r_scan  <= nxt;
                    if (own_q != '0) begin
                        r_base <= nxt;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
            end
            OP_A_W2: begin
                r_rover <= rov_alloc;
            end
            OP_F_CHK: begin
                r_g     <= IDX_W'(f_g);
                r_ggran <= gran_q;
                r_other <= prev_q;
            end
            OP_F_M1: begin
                if (own_q == '0) begin
                    r_g     <= r_other;
                    r_ggran <= m_sum;
                    if (r_rover == r_g) begin
                        r_rover <= r_other;
                    end
                end
            end
            OP_F_RD2: begin
                r_other <= f_next;
            end
            OP_F_M2: begin
                if ((own_q == '0) && (r_rover == r_other)) begin
                    r_rover <= r_g;
                end
            end
            default: begin
                r_clr <= r_clr;
            end
        endcase
        if (i_cmd.ld_out) begin
            r_out_off <= i_cmd.ok_alloc ? base_bytes[OFF_W-1:0] : '0;
        end
    end

    assign o_flags = '{
        clr_last: (r_clr == '1),
        is_free:  r_is_free,
        zero_tag: (r_tag == '0),
        bad_off:  bad_off,
        a_found:  ev_found,
        a_fail:   ev_fail,
        f_bad:    bad_off || !map_q,
        f_dbl:    (own_q == '0)
    };

    assign o_payload_offset = r_out_off;
endmodule
